>>> rtl/gci_pkg.sv
// Shared constants, types and tables for the Gompertz conditional increment unit.
package gci_pkg;

    localparam int WORD_WIDTH   = 32;
    localparam int SAT_WIDTH    = (WORD_WIDTH > 32) ? 32 : WORD_WIDTH;

    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 32;
    localparam logic [CFG_IDX_W-1:0] REG_CURVE_SCALE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CURVE_RATE  = 1'b1;
    localparam logic [30:0] SCALE_RESET = 31'd83550208;
    localparam logic [31:0] RATE_RESET  = 32'd852256;

    localparam int E_W          = 40;
    localparam int K_W          = 8;
    localparam int M_W          = 33;
    localparam int T_W          = 32;
    localparam int RECIP_W      = 35;
    localparam int TAYLOR_TERMS = 14;
    localparam int ITER         = TAYLOR_TERMS - 1;

    localparam logic [31:0] LN2_Q32   = 32'd2977044472;
    localparam logic [20:0] RECIP_LN2 = 21'd1512775;
    localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
    localparam logic [38:0] V_LIMIT   = 39'h40_0000_0000;
    localparam logic [56:0] E_NEG_LIMIT = 57'h40_0000_0000;
    localparam logic [56:0] E_POS_LIMIT = 57'h20_0000_0000;
    localparam int A_FRAC       = 24;
    localparam int SHIFT_PAD    = 22;

    localparam logic [31:0] SAT_LIMIT   = 32'(64'(1) << (SAT_WIDTH - 1));
    localparam logic [31:0] SAT_POS_MAX = SAT_LIMIT - 32'd1;

    typedef struct packed {
        logic neg;
        logic degen;
    } div_flags_t;

    // floor(2^35 / n)
    function automatic logic [RECIP_W-1:0] gci_recip(input logic [3:0] n);
        case (n)
            4'd2:    return 35'd17179869184;
            4'd3:    return 35'd11453246122;
            4'd4:    return 35'd8589934592;
            4'd5:    return 35'd6871947673;
            4'd6:    return 35'd5726623061;
            4'd7:    return 35'd4908534052;
            4'd8:    return 35'd4294967296;
            4'd9:    return 35'd3817748707;
            4'd10:   return 35'd3435973836;
            4'd11:   return 35'd3123612578;
            4'd12:   return 35'd2863311530;
            4'd13:   return 35'd2643056797;
            4'd14:   return 35'd2454267026;
            default: return '0;
        endcase
    endfunction

endpackage

>>> rtl/gci_exp.sv
// Pipelined exp(e) = m * 2^k with range reduction and Taylor series.
module gci_exp import gci_pkg::*; (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_valid,
    input  logic [E_W-1:0] in_e,
    output logic           out_valid,
    output logic [M_W-1:0] out_m,
    output logic [K_W-1:0] out_k
);

    logic           v1_reg, v2_reg;
    logic [E_W-1:0] e1_reg;
    logic [41:0]    prod1_reg;
    logic [33:0]    r0_reg;
    logic [K_W-1:0] k2_reg;

    logic [41:0]    prod1_next;
    logic [K_W-1:0] k_est;
    logic [41:0]    kl;
    logic [41:0]    r0_full;

    logic           vld_s   [0:ITER];
    logic [T_W-1:0] term_s  [0:ITER];
    logic [T_W-1:0] r_s     [0:ITER];
    logic [M_W-1:0] sum_s   [0:ITER];
    logic [K_W-1:0] k_s     [0:ITER];

    assign prod1_next = 42'($signed(in_e[E_W-1:20])) * 42'($signed({1'b0, RECIP_LN2}));
    assign k_est      = prod1_reg[39:32];
    assign kl         = 42'($signed(k_est)) * 42'($signed({1'b0, LN2_Q32}));
    assign r0_full    = 42'($signed(e1_reg)) - kl;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            vld_s[0] <= 1'b0;
        end else if (en) begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            vld_s[0] <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e1_reg    <= in_e;
            prod1_reg <= prod1_next;
            r0_reg    <= r0_full[33:0];
            k2_reg    <= k_est;
            if (r0_reg[33]) begin
                term_s[0] <= T_W'(r0_reg + 34'(LN2_Q32));
                k_s[0]    <= k2_reg - 8'd1;
            end else if (r0_reg[32:0] >= {1'b0, LN2_Q32}) begin
                term_s[0] <= T_W'(r0_reg - 34'(LN2_Q32));
                k_s[0]    <= k2_reg + 8'd1;
            end else begin
                term_s[0] <= r0_reg[T_W-1:0];
                k_s[0]    <= k2_reg;
            end
        end
    end

    assign r_s[0]   = term_s[0];
    assign sum_s[0] = ONE_Q32 + M_W'(term_s[0]);

    for (genvar i = 0; i < ITER; i++) begin : g_term
        localparam logic [3:0] N = 4'(i + 2);
        localparam logic [RECIP_W-1:0] RM = gci_recip(N);

        logic           a_vld_reg, b_vld_reg;
        logic [63:0]    a_prod_reg;
        logic [T_W-1:0] a_r_reg, b_r_reg;
        logic [M_W-1:0] a_sum_reg, b_sum_reg;
        logic [K_W-1:0] a_k_reg, b_k_reg;
        logic [T_W-1:0] b_p_reg;
        logic [66:0]    b_pm_reg;
        logic [T_W-1:0] q_est;
        logic [35:0]    q_n;
        logic [35:0]    rem;
        logic [T_W-1:0] q_next;

        assign q_est  = b_pm_reg[66:35];
        assign q_n    = 36'(q_est) * 36'(N);
        assign rem    = 36'(b_p_reg) - q_n;
        assign q_next = (rem >= 36'(N)) ? q_est + 32'd1 : q_est;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                a_vld_reg  <= 1'b0;
                b_vld_reg  <= 1'b0;
                vld_s[i+1] <= 1'b0;
            end else if (en) begin
                a_vld_reg  <= vld_s[i];
                b_vld_reg  <= a_vld_reg;
                vld_s[i+1] <= b_vld_reg;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                a_prod_reg <= 64'(term_s[i]) * 64'(r_s[i]);
                a_r_reg    <= r_s[i];
                a_sum_reg  <= sum_s[i];
                a_k_reg    <= k_s[i];
                b_p_reg    <= a_prod_reg[63:32];
                b_pm_reg   <= 67'(a_prod_reg[63:32]) * 67'(RM);
                b_r_reg    <= a_r_reg;
                b_sum_reg  <= a_sum_reg;
                b_k_reg    <= a_k_reg;
                term_s[i+1] <= q_next;
                r_s[i+1]    <= b_r_reg;
                sum_s[i+1]  <= b_sum_reg + M_W'(q_next);
                k_s[i+1]    <= b_k_reg;
            end
        end
    end

    assign out_valid = vld_s[ITER];
    assign out_m     = sum_s[ITER];
    assign out_k     = k_s[ITER];

endmodule

>>> rtl/gci_div.sv
// Pipelined restoring divider with saturation to the signed result format.
module gci_div import gci_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  logic [62:0] in_numer,
    input  logic [32:0] in_den,
    input  div_flags_t  in_flags,
    output logic        out_valid,
    output logic [31:0] out_increment,
    output logic        out_degenerate
);

    logic        vld_s   [0:32];
    logic [62:0] rem_s   [0:32];
    logic [31:0] q_s     [0:32];
    logic [32:0] den_s   [0:32];
    div_flags_t  flags_s [0:32];
    logic        ovf_s   [0:32];

    logic        out_valid_reg;
    logic [31:0] out_increment_reg;
    logic        out_degenerate_reg;
    logic [31:0] inc_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_s[0] <= 1'b0;
        end else if (en) begin
            vld_s[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_s[0]   <= in_numer;
            q_s[0]     <= '0;
            den_s[0]   <= in_den;
            flags_s[0] <= in_flags;
            ovf_s[0]   <= 65'(in_numer) >= {in_den, 32'd0};
        end
    end

    for (genvar s = 0; s < 32; s++) begin : g_step
        localparam int J = 31 - s;
        logic [64:0] trial;
        logic        ge;

        assign trial = 65'(den_s[s]) << J;
        assign ge    = 65'(rem_s[s]) >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_s[s+1] <= 1'b0;
            end else if (en) begin
                vld_s[s+1] <= vld_s[s];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_s[s+1]   <= ge ? 63'(65'(rem_s[s]) - trial) : rem_s[s];
                q_s[s+1]     <= q_s[s] | (32'(ge) << J);
                den_s[s+1]   <= den_s[s];
                flags_s[s+1] <= flags_s[s];
                ovf_s[s+1]   <= ovf_s[s];
            end
        end
    end

    always_comb begin
        if (flags_s[32].degen) begin
            inc_next = '0;
        end else if (flags_s[32].neg) begin
            if (ovf_s[32] || q_s[32] > SAT_LIMIT) begin
                inc_next = 32'd0 - SAT_LIMIT;
            end else begin
                inc_next = 32'd0 - q_s[32];
            end
        end else begin
            if (ovf_s[32] || q_s[32] > SAT_POS_MAX) begin
                inc_next = SAT_POS_MAX;
            end else begin
                inc_next = q_s[32];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= vld_s[32];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_increment_reg  <= inc_next;
            out_degenerate_reg <= flags_s[32].degen;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_increment  = out_increment_reg;
    assign out_degenerate = out_degenerate_reg;

endmodule

>>> rtl/gompertz_conditional_increment_unit.sv
// Top level: Gompertz conditional increment, two curve lanes, divider and output skid.
// Throughput: one item per cycle while the skid register is empty; the whole pipeline
// advances on a single enable.
// A two-entry output register plus skid lets the pipe run while a result waits.
// Reset (synchronous, aresetn low): clears all valid bits, loads default scale and rate.
module gompertz_conditional_increment_unit import gci_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [31:0]    s_position,
    input  logic signed [31:0]    s_step,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [31:0]    m_increment,
    output logic                  m_degenerate
);

    logic [30:0] scale_reg;
    logic [31:0] rate_reg;

    logic        en;
    logic        in_valid_reg;
    logic [32:0] t_reg [0:1];

    logic        g2_valid_reg, g3_valid_reg, g4_valid_reg, g5_valid_reg, g6_valid_reg;
    logic        g7_valid_reg, g8_valid_reg;

    logic        neg_b;
    logic [31:0] mag_b;

    logic           x1_valid [0:1];
    logic [M_W-1:0] x1_m     [0:1];
    logic [K_W-1:0] x1_k     [0:1];
    logic           x2_valid [0:1];
    logic [M_W-1:0] x2_m     [0:1];
    logic [K_W-1:0] x2_k     [0:1];
    logic [32:0]    g7_f_reg [0:1];

    logic [62:0] g8_numer_reg;
    logic [32:0] g8_den_reg;
    div_flags_t  g8_flags_reg;
    logic [32:0] den_next;
    logic [32:0] diff_next;
    logic        neg_next;

    logic        pipe_valid;
    logic [31:0] pipe_inc;
    logic        pipe_degen;

    logic        m_valid_reg, skid_valid_reg;
    logic [31:0] m_increment_reg, skid_increment_reg;
    logic        m_degenerate_reg, skid_degenerate_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= SCALE_RESET;
            rate_reg  <= RATE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_CURVE_SCALE: scale_reg <= cfg_data[30:0];
                REG_CURVE_RATE:  rate_reg  <= cfg_data;
            endcase
        end
    end

    assign en      = !skid_valid_reg;
    assign s_ready = en;

    assign neg_b = rate_reg[31];
    assign mag_b = neg_b ? (32'd0 - rate_reg) : rate_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            g2_valid_reg <= 1'b0;
            g3_valid_reg <= 1'b0;
            g4_valid_reg <= 1'b0;
            g5_valid_reg <= 1'b0;
            g6_valid_reg <= 1'b0;
            g7_valid_reg <= 1'b0;
            g8_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_valid;
            g2_valid_reg <= in_valid_reg;
            g3_valid_reg <= g2_valid_reg;
            g4_valid_reg <= x1_valid[0] & x1_valid[1];
            g5_valid_reg <= g4_valid_reg;
            g6_valid_reg <= g5_valid_reg;
            g7_valid_reg <= x2_valid[0] & x2_valid[1];
            g8_valid_reg <= g7_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg[0] <= 33'(s_position);
            t_reg[1] <= 33'(s_position) + 33'(s_step);
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic        neg_t;
        logic [32:0] mag_t;
        logic [64:0] g2_prod_reg;
        logic        g2_same_reg;
        logic [56:0] emag;
        logic        e_neg;
        logic [E_W-1:0] e_next;
        logic [E_W-1:0] g3_e_reg;
        logic [63:0] g4_p_reg;
        logic [K_W-1:0] g4_k_reg;
        logic [K_W-1:0] amt;
        logic [85:0] g5_w_reg;
        logic [38:0] v;
        logic [E_W-1:0] g6_e_reg;

        assign neg_t = t_reg[l][32];
        assign mag_t = neg_t ? (33'd0 - t_reg[l]) : t_reg[l];

        assign emag  = g2_prod_reg[64:8];
        assign e_neg = g2_same_reg && (emag != '0);

        always_comb begin
            if (e_neg) begin
                e_next = (emag > E_NEG_LIMIT) ? (40'd0 - 40'(E_NEG_LIMIT))
                                              : (40'd0 - 40'(emag));
            end else begin
                e_next = (emag > E_POS_LIMIT) ? 40'(E_POS_LIMIT) : 40'(emag);
            end
        end

        assign amt = K_W'(SHIFT_PAD + A_FRAC) - g4_k_reg;
        assign v   = (g5_w_reg > 86'(V_LIMIT)) ? V_LIMIT : g5_w_reg[38:0];

        always_ff @(posedge aclk) begin
            if (en) begin
                g2_prod_reg <= 65'(mag_b) * 65'(mag_t);
                g2_same_reg <= (neg_b == neg_t);
                g3_e_reg    <= e_next;
                g4_p_reg    <= 64'(scale_reg) * 64'(x1_m[l]);
                g4_k_reg    <= x1_k[l];
                g5_w_reg    <= {g4_p_reg, SHIFT_PAD'(0)} >> amt;
                g6_e_reg    <= 40'd0 - 40'(v);
                g7_f_reg[l] <= x2_k[l][K_W-1] ? (x2_m[l] >> (K_W'(0) - x2_k[l])) : x2_m[l];
            end
        end

        gci_exp u_exp_inner (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (g3_valid_reg),
            .in_e      (g3_e_reg),
            .out_valid (x1_valid[l]),
            .out_m     (x1_m[l]),
            .out_k     (x1_k[l])
        );

        gci_exp u_exp_outer (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (g6_valid_reg),
            .in_e      (g6_e_reg),
            .out_valid (x2_valid[l]),
            .out_m     (x2_m[l]),
            .out_k     (x2_k[l])
        );
    end

    assign den_next  = ONE_Q32 - g7_f_reg[0];
    assign neg_next  = g7_f_reg[1] < g7_f_reg[0];
    assign diff_next = neg_next ? (g7_f_reg[0] - g7_f_reg[1]) : (g7_f_reg[1] - g7_f_reg[0]);

    always_ff @(posedge aclk) begin
        if (en) begin
            g8_numer_reg       <= 63'(diff_next) << 30;
            g8_den_reg         <= den_next;
            g8_flags_reg.neg   <= neg_next;
            g8_flags_reg.degen <= (den_next == '0);
        end
    end

    gci_div u_div (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (en),
        .in_valid       (g8_valid_reg),
        .in_numer       (g8_numer_reg),
        .in_den         (g8_den_reg),
        .in_flags       (g8_flags_reg),
        .out_valid      (pipe_valid),
        .out_increment  (pipe_inc),
        .out_degenerate (pipe_degen)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!m_valid_reg || m_ready) begin
                if (skid_valid_reg) begin
                    m_valid_reg    <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    m_valid_reg <= pipe_valid;
                end
            end else if (pipe_valid && !skid_valid_reg) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                m_increment_reg  <= skid_increment_reg;
                m_degenerate_reg <= skid_degenerate_reg;
            end else begin
                m_increment_reg  <= pipe_inc;
                m_degenerate_reg <= pipe_degen;
            end
        end
        if (m_valid_reg && !m_ready && !skid_valid_reg) begin
            skid_increment_reg  <= pipe_inc;
            skid_degenerate_reg <= pipe_degen;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_increment  = m_increment_reg;
    assign m_degenerate = m_degenerate_reg;

endmodule

>>> tb/gci_checker.sv
// Scoreboard for the Gompertz conditional increment unit: predicts and compares results.
module gci_checker import gci_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic signed [31:0]    s_position,
    input  logic signed [31:0]    s_step,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic signed [31:0]    m_increment,
    input  logic                  m_degenerate,
    output int                    fail_count,
    output int                    pending,
    output int                    result_count,
    output int                    degen_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] increment;
        logic               degenerate;
    } outcome_t;

    localparam longint LN2 = 64'd2977044472;
    localparam logic [63:0] ONE = 64'h1_0000_0000;
    localparam logic [63:0] VMAX = 64'd64 << 32;

    logic [30:0]        scale_q;
    logic signed [31:0] rate_q;
    outcome_t           expected_q[$];

    function automatic logic [63:0] exp_split(input longint e, output int k);
        longint q, r;
        logic [63:0] sum, term;
        q = e / LN2;
        r = e - q * LN2;
        if (r < 0) begin
            r += LN2;
            q--;
        end
        sum = ONE;
        term = ONE;
        for (int n = 1; n <= TAYLOR_TERMS; n++) begin
            term = ((term * 64'(r)) >> 32) / 64'(n);
            sum += term;
        end
        k = int'(q);
        return sum;
    endfunction

    function automatic logic [63:0] curve_at(input longint t);
        logic neg_b, neg_t, e_neg;
        logic [63:0] mag_b, mag_t, emag, m, p, v;
        longint e, rb;
        int k, sh;
        rb = longint'(rate_q);
        neg_b = rb < 0;
        neg_t = t < 0;
        mag_b = neg_b ? 64'(-rb) : 64'(rb);
        mag_t = neg_t ? 64'(-t) : 64'(t);
        emag = (mag_b * mag_t) >> 8;
        e_neg = (neg_b == neg_t) && emag != 0;
        if (e_neg) begin
            if (emag > (64'd64 << 32)) emag = 64'd64 << 32;
            e = -longint'(emag);
        end else begin
            if (emag > (64'd32 << 32)) emag = 64'd32 << 32;
            e = longint'(emag);
        end
        m = exp_split(e, k);
        p = 64'(scale_q) * m;
        sh = k - 24;
        if (p == 0) v = 0;
        else if (sh >= 0) begin
            if (sh >= 38 || p > (VMAX >> sh)) v = VMAX;
            else v = p << sh;
        end else v = (-sh >= 64) ? 64'd0 : (p >> (-sh));
        if (v > VMAX) v = VMAX;
        m = exp_split(-longint'(v), k);
        if (k >= 0) return m;
        return (-k >= 64) ? 64'd0 : (m >> (-k));
    endfunction

    function automatic outcome_t conditional_increment(input logic signed [31:0] x,
                                                       input logic signed [31:0] dx);
        logic [63:0] f0, f1, d, qmag, lim;
        logic neg;
        outcome_t o;
        f0 = curve_at(longint'(x));
        f1 = curve_at(longint'(x) + longint'(dx));
        d = ONE - f0;
        lim = 64'd1 << (SAT_WIDTH - 1);
        if (d == 0) begin
            o.increment = '0;
            o.degenerate = 1'b1;
            return o;
        end
        neg = f1 < f0;
        qmag = ((neg ? (f0 - f1) : (f1 - f0)) << 30) / d;
        if (neg) begin
            if (qmag > lim) qmag = lim;
            o.increment = 32'(64'd0 - qmag);
        end else begin
            if (qmag > lim - 1) qmag = lim - 1;
            o.increment = 32'(qmag);
        end
        o.degenerate = 1'b0;
        return o;
    endfunction

    task automatic report(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        result_count = 0;
        degen_count = 0;
    end

    assign pending = expected_q.size();

    always @(posedge aclk) begin
        outcome_t got, want;
        if (!aresetn) begin
            scale_q <= SCALE_RESET;
            rate_q  <= RATE_RESET;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == REG_CURVE_SCALE) scale_q <= cfg_data[30:0];
                else if (cfg_index == REG_CURVE_RATE) rate_q <= cfg_data;
            end
            if (s_valid && s_ready)
                expected_q.push_back(conditional_increment(s_position, s_step));
            if (m_valid && m_ready) begin
                got.increment = m_increment;
                got.degenerate = m_degenerate;
                result_count++;
                if (expected_q.size() == 0) begin
                    report("result with no item outstanding");
                end else begin
                    want = expected_q.pop_front();
                    if (want.degenerate) degen_count++;
                    if (got.increment !== want.increment)
                        report($sformatf("increment got %0d want %0d",
                                         got.increment, want.increment));
                    if (got.degenerate !== want.degenerate)
                        report($sformatf("degenerate got %0b want %0b",
                                         got.degenerate, want.degenerate));
                end
            end
        end
    end
endmodule

>>> tb/tb.sv
// Testbench top: stimulus, configuration phases and verdict for the increment unit.
module tb;
    import gci_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic signed [31:0]    s_position;
    logic signed [31:0]    s_step;
    logic                  m_valid;
    logic                  m_ready;
    logic signed [31:0]    m_increment;
    logic                  m_degenerate;
    logic                  took_q;
    logic                  busy_out;
    int                    fail_count, pending, result_count, degen_count;
    int                    items_sent, cfg_writes;

    gompertz_conditional_increment_unit dut (.*);
    gci_checker chk (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

    always @(posedge aclk) took_q <= s_valid && s_ready;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // output stalls: each stall holds m_ready low for a whole gap
    initial begin
        int g;
        m_ready = 1'b0;
        busy_out = 1'b0;
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 199) == 0) busy_out = ~busy_out;
            if (busy_out) begin
                m_ready = 1'b1;
            end else begin
                g = gap_len();
                if (g == 0) begin
                    m_ready = 1'b1;
                end else begin
                    m_ready = 1'b0;
                    repeat (g - 1) @(negedge aclk);
                end
            end
        end
    end

    task automatic send_item(input logic [31:0] x, input logic [31:0] dx);
        int g;
        g = busy_out ? 0 : gap_len();
        repeat (g) @(negedge aclk);
        s_valid = 1'b1;
        s_position = x;
        s_step = dx;
        do @(negedge aclk); while (!took_q);
        s_valid = 1'b0;
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        while (pending != 0) @(negedge aclk);
        repeat (140) @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        cfg_writes++;
    endtask

    task automatic random_items(input int n);
        logic [31:0] x, dx;
        repeat (n) begin
            if ($urandom_range(0, 9) < 7) begin
                x = 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
                dx = 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
            end else begin
                x = $urandom;
                dx = $urandom;
            end
            send_item(x, dx);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_CURVE_SCALE;
        cfg_data = '0;
        s_valid = 1'b0;
        s_position = '0;
        s_step = '0;
        items_sent = 0;
        cfg_writes = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // defaults, field extremes, huge exponents, tiny remainder
        send_item(32'h0, 32'h0);
        send_item(32'h8000_0000, 32'h7FFF_FFFF);
        send_item(32'h7FFF_FFFF, 32'h8000_0000);
        send_item(32'h8000_0000, 32'h0);
        send_item(32'h7FFF_FFFF, 32'h0);
        send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(32'h8000_0000, 32'h8000_0000);
        send_item(32'h0, 32'h1);
        send_item(32'h0001_0000, 32'h0001_0000);
        send_item(32'hFF9C_0000, 32'h00C8_0000);
        send_item(32'h0032_0000, 32'hFFF6_0000);
        send_item(32'h0190_0000, 32'hFE00_0000);
        send_item(32'h00C8_0000, 32'hFFFF_FFFF);
        random_items(300);

        // zero scale, written with the unused top bit set
        write_reg(REG_CURVE_SCALE, 32'h8000_0000);
        send_item(32'h0, 32'h0001_0000);
        send_item(32'h8000_0000, 32'h7FFF_FFFF);
        random_items(100);

        write_reg(REG_CURVE_SCALE, 32'h7FFF_FFFF);
        write_reg(REG_CURVE_RATE, 32'h8000_0000);
        random_items(200);

        write_reg(REG_CURVE_SCALE, 32'h0000_0001);
        write_reg(REG_CURVE_RATE, 32'h7FFF_FFFF);
        random_items(150);

        write_reg(REG_CURVE_SCALE, 32'(SCALE_RESET));
        write_reg(REG_CURVE_RATE, 32'h0);
        random_items(100);

        repeat (5) begin
            write_reg(REG_CURVE_SCALE, $urandom_range(0, 32'h1000_0000));
            write_reg(REG_CURVE_RATE, ($urandom_range(0, 1) != 0) ? $urandom
                      : 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000));
            random_items(150);
        end

        while (pending != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
        $display("Sent %0d items over %0d register writes; %0d results checked",
                 items_sent, cfg_writes, result_count);
        $display("Degenerate-tail results seen: %0d", degen_count);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
